>>> sv/lsd_pkg.sv
// shared types and constants for the lifo list search and delete block
`timescale 1ns / 1ps
`default_nettype none
package lsd_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [31:0] t_word;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_REMOVE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic load_left;
        logic load_right;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> sv/lifo_list_search_delete_core.sv
// top level: lifo list with search and delete, built as a row of shifting cells
//
// usage:
//   a transaction is accepted at a rising edge with start high and busy low;
//   i_action selects insert at head, pop head, search or remove first match,
//   and i_value carries the operand.
//   every transaction gives exactly one result, shown for one cycle with
//   o_done high: o_status, o_popped_value and o_entry_count.
//   the accepting edge enters the exec state, where busy is high and no new
//   transaction is taken; the edge that leaves it registers the result and
//   raises o_done. the accepting edge registers every cell's compare of its
//   entry with the value, the busy cycle resolves the first match and shifts
//   the cells.
//   the receiver cannot stall; o_done is a strobe and must be taken as it
//   comes.
//   reset (i_rst_n low, synchronous) empties the list and clears busy and
//   o_done; entry storage itself is not cleared, only the count.
`timescale 1ns / 1ps
`default_nettype none
module lifo_list_search_delete_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    output logic               busy,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_popped_value,
    output logic [6:0]         o_entry_count
);
    import lsd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state           r_state;
    t_action          r_action;
    t_word            r_value;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          n_status;
    t_word            n_popped;

    t_word            w_data  [CAPACITY];
    t_cell_ctl        w_ctl   [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_below;
    logic             w_empty;
    logic             w_full;
    logic             w_found;
    logic             w_cmp_en;

    assign busy     = (r_state == ST_EXEC);
    assign w_cmp_en = start && !busy;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_word w_left;
            t_word w_right;
            if (g == 0) begin : g_head
                assign w_left = r_value;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            assign w_occ[g] = (CNT_W'(g) < r_count);
            lsd_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl[g]),
                .i_cmp_en (w_cmp_en),
                .i_key    (t_word'(i_value)),
                .i_left   (w_left),
                .i_right  (w_right),
                .o_data   (w_data[g]),
                .o_match  (w_match[g])
            );
        end
    endgenerate

    // first match from the head: cells below it keep, the rest take from the right
    assign w_hit   = w_match & w_occ;
    assign w_found = |w_hit;
    assign w_below = ~w_hit & (w_hit - CAPACITY'(1));
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_count  = r_count;
        n_status = STAT_OK;
        n_popped = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctl[i] = '0;
        end
        if (r_state == ST_EXEC) begin
            unique case (r_action)
                ACT_INSERT: begin
                    if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            w_ctl[i].load_left = 1'b1;
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                end
                ACT_POP: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            w_ctl[i].load_right = 1'b1;
                        end
                        n_popped = w_data[0];
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                ACT_SEARCH: begin
                    n_status = w_found ? STAT_OK : STAT_NOT_FOUND;
                end
                ACT_REMOVE: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else if (w_found) begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            w_ctl[i].load_right = ~w_below[i];
                        end
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_status = STAT_NOT_FOUND;
                    end
                end
                default: begin
                    n_status = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_action <= t_action'(i_action);
                        r_value  <= t_word'(i_value);
                        r_state  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    o_done         <= 1'b1;
                    o_status       <= n_status;
                    o_popped_value <= n_popped;
                    o_entry_count  <= 7'(n_count);
                    r_count        <= n_count;
                    r_state        <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STAT_FULL)) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full reported while list not full");

    a_popped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STAT_OK)) |-> (o_popped_value == '0))
        else $error("nonzero popped value on a failed transaction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1))
            || (r_count == $past(r_count) - CNT_W'(1))))
        else $error("entry count moved by more than one");

endmodule
`default_nettype wire

>>> sv/lsd_cell.sv
// one list cell: holds an entry, shifts to either neighbor, compares against a key
`timescale 1ns / 1ps
`default_nettype none
module lsd_cell (
    input  logic               i_clk,
    input  lsd_pkg::t_cell_ctl i_ctl,
    input  logic               i_cmp_en,
    input  lsd_pkg::t_word     i_key,
    input  lsd_pkg::t_word     i_left,
    input  lsd_pkg::t_word     i_right,
    output lsd_pkg::t_word     o_data,
    output logic               o_match
);
    import lsd_pkg::*;

    t_word r_data;
    logic  r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_left) begin
            r_data <= i_left;
        end else if (i_ctl.load_right) begin
            r_data <= i_right;
        end
        if (i_cmp_en) begin
            r_match <= (r_data == i_key);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule
`default_nettype wire

>>> sim/tb.sv
// testbench for the lifo list search and delete core: directed table plus random phases
`timescale 1ns / 1ps
module tb;
    import lsd_pkg::*;

    typedef struct packed {
        t_status    status;
        t_word      popped;
        logic [6:0] count;
    } t_reply;

    typedef struct packed {
        t_action act;
        t_word   val;
        bit      typed;
        t_reply  reply;
    } t_row;

    localparam int N_ROWS    = 23;
    localparam int N_PHASES  = 6;
    localparam int LIMIT     = 60000;

    localparam int PHASE_LEN [N_PHASES] = '{120, 90, 100, 60, 60, 50};
    localparam int PHASE_INS [N_PHASES] = '{88, 12, 40, 88, 12, 40};

    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{ACT_POP,    32'h0000_0000, 1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
        '{ACT_REMOVE, 32'h0000_0005, 1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
        '{ACT_SEARCH, 32'h0000_0000, 1'b1, '{STAT_NOT_FOUND, 32'h0, 7'd0}},
        '{ACT_INSERT, 32'h8000_0000, 1'b1, '{STAT_OK,        32'h0, 7'd1}},
        '{ACT_INSERT, 32'h7FFF_FFFF, 1'b1, '{STAT_OK,        32'h0, 7'd2}},
        '{ACT_INSERT, 32'h0000_0000, 1'b1, '{STAT_OK,        32'h0, 7'd3}},
        '{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, '{STAT_OK,        32'h0, 7'd4}},
        '{ACT_SEARCH, 32'h8000_0000, 1'b1, '{STAT_OK,        32'h0, 7'd4}},
        '{ACT_SEARCH, 32'h0000_0001, 1'b1, '{STAT_NOT_FOUND, 32'h0, 7'd4}},
        '{ACT_INSERT, 32'h0000_0007, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_INSERT, 32'h7FFF_FFFF, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_INSERT, 32'h0000_0007, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_REMOVE, 32'h0000_0007, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_SEARCH, 32'h0000_0007, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_REMOVE, 32'h0000_1234, 1'b1, '{STAT_NOT_FOUND, 32'h0, 7'd6}},
        '{ACT_REMOVE, 32'h7FFF_FFFF, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_POP,    32'h0000_0000, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_REMOVE, 32'h8000_0000, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_SEARCH, 32'h8000_0000, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_REMOVE, 32'h0000_0000, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_POP,    32'h0000_0000, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_POP,    32'h0000_0000, 1'b0, '{STAT_OK,        32'h0, 7'd0}},
        '{ACT_POP,    32'h0000_0000, 1'b1, '{STAT_EMPTY,     32'h0, 7'd0}}
    };

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic [1:0]  i_action = 2'd0;
    logic signed [31:0] i_value = 32'sd0;
    logic        busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic signed [31:0] o_popped_value;
    logic [6:0]  o_entry_count;

    bit     hand_typed = 1'b0;
    t_reply hand_reply = '0;

    t_word  shadow_words [CAPACITY];
    int     shadow_count = 0;
    t_reply reply_q [$];
    int     fail_count = 0;
    int     cycle_count = 0;

    lifo_list_search_delete_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_action       (i_action),
        .i_value        (i_value),
        .busy           (busy),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int find_word(t_word val);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_words[i] == val) return i;
        end
        return shadow_count;
    endfunction

    function automatic void drop_at(int pos);
        for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
        shadow_count--;
    endfunction

    function automatic t_reply apply_list_op(t_action act, t_word val);
        t_reply r;
        int     pos;
        r = '{STAT_OK, 32'h0, 7'd0};
        case (act)
            ACT_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = shadow_count; i > 0; i--) shadow_words[i] = shadow_words[i - 1];
                    shadow_words[0] = val;
                    shadow_count++;
                end
            end
            ACT_POP: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.popped = shadow_words[0];
                    drop_at(0);
                end
            end
            ACT_SEARCH: begin
                if (find_word(val) >= shadow_count) r.status = STAT_NOT_FOUND;
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    pos = find_word(val);
                    if (pos < shadow_count) drop_at(pos);
                    else r.status = STAT_NOT_FOUND;
                end
            end
        endcase
        r.count = 7'(shadow_count);
        return r;
    endfunction

    // results first, then the transaction accepted at this edge
    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (i_rst_n) begin
            if (o_done) begin
                if (reply_q.size() == 0) begin
                    $error("result with no transaction pending: status %0d", o_status);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_popped_value !== want.popped) begin
                        $error("popped_value: expected %h, got %h", want.popped, o_popped_value);
                        fail_count++;
                    end
                    if (o_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                got = apply_list_op(t_action'(i_action), i_value);
                reply_q.push_back(hand_typed ? hand_reply : got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic issue_op(input t_action act, input t_word val, input bit typed,
                            input t_reply reply);
        start      <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        hand_typed <= typed;
        hand_reply <= reply;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic settle_all;
        idle_for(1);
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 11));
    endtask

    initial begin
        t_action act;
        t_word   val;
        int      pick;
        bit      idle_ok;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            maybe_idle(1'b1);
            issue_op(DIR_ROWS[k].act, DIR_ROWS[k].val, DIR_ROWS[k].typed, DIR_ROWS[k].reply);
        end
        settle_all();

        for (int p = 0; p < N_PHASES; p++) begin
            idle_ok = (p != N_PHASES - 1);
            for (int k = 0; k < PHASE_LEN[p]; k++) begin
                if ($urandom_range(0, 99) < PHASE_INS[p]) begin
                    act = ACT_INSERT;
                end else begin
                    case ($urandom_range(0, 2))
                        0:       act = ACT_POP;
                        1:       act = ACT_SEARCH;
                        default: act = ACT_REMOVE;
                    endcase
                end
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    // hits on held entries for lookups, a small pool for duplicates
                    if (act != ACT_INSERT && shadow_count > 0)
                        val = shadow_words[$urandom_range(0, shadow_count - 1)];
                    else
                        val = 32'($urandom_range(0, 15));
                end else if (pick == 5) begin
                    case ($urandom_range(0, 3))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h7FFF_FFFF;
                        2:       val = 32'hFFFF_FFFF;
                        default: val = 32'h0000_0000;
                    endcase
                end else begin
                    val = $urandom;
                end
                maybe_idle(idle_ok);
                issue_op(act, val, 1'b0, '0);
            end
            if (idle_ok) settle_all();
        end

        settle_all();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> lifo_list_search_delete_core.f
sv/lsd_pkg.sv
sv/lsd_cell.sv
sv/lifo_list_search_delete_core.sv
sim/tb.sv
